// ===== hw/rtl/packet_header_parse_and_verify_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet header parse and verify block
// Clocked property checks; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PACKET_HEADER_PARSE_AND_VERIFY_TOP_ASSERT_SVH
`define PACKET_HEADER_PARSE_AND_VERIFY_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// check disabled while reset is asserted
`define PHV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check that also holds through reset
`define PHV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PHV_ASSERT(lbl, clk, rstn, prop, msg)
`define PHV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/phv_pkg.sv =====
// ----------------------------------------------------------------------------
// phv_pkg
// Shared types, constants and the end-around-carry add for the header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package phv_pkg;

  // header byte positions (big-endian fields)
  localparam logic [15:0] SEQ_END    = 16'd4;
  localparam logic [15:0] ACK_END    = 16'd8;
  localparam logic [15:0] CSUM_HI    = 16'd8;
  localparam logic [15:0] CSUM_LO    = 16'd9;
  localparam logic [15:0] CSUM_END   = 16'd10;
  localparam logic [15:0] LEN_END    = 16'd12;
  localparam logic [15:0] HDR_BYTES  = 16'd14;
  localparam logic [15:0] IDX_MAX    = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDER_HDR = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_LEN_SHORT = 3'd3,
    ST_CSUM_BAD  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        packet_done;
    status_t     status;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [7:0]  packet_type;
    logic [7:0]  window_size;
    logic [15:0] payload_length;
  } rslt_t;

  // ones' complement add with end-around carry
  function automatic logic [15:0] add_carry(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/phv_in_stage.sv =====
// ----------------------------------------------------------------------------
// phv_in_stage
// Input register: one item per cycle unless stalled, held until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "packet_header_parse_and_verify_top_assert.svh"

module phv_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire phv_pkg::item_t in_item,
  output logic               item_valid,
  output phv_pkg::item_t     item,
  input  wire logic          take
);

  logic           vld_r, vld_nxt;
  phv_pkg::item_t item_r;
  logic           load;

  // stall only while a held item cannot move on this cycle
  assign in_stall = vld_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

  `PHV_ASSERT_ALWAYS(a_stall_needs_item, clk, in_stall |-> vld_r, "stall without held item")
  `PHV_ASSERT(a_take_needs_item, clk, rst_n, take |-> vld_r, "core took an empty stage")
  `PHV_ASSERT(a_held_item_kept, clk, rst_n, (vld_r && !take) |=> (vld_r && $stable(item_r)), "held item lost")

endmodule

`default_nettype wire

// ===== hw/rtl/phv_core.sv =====
// ----------------------------------------------------------------------------
// phv_core
// Header decode, checksum accumulation, final status and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "packet_header_parse_and_verify_top_assert.svh"

module phv_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           item_valid,
  input  wire phv_pkg::item_t item,
  output logic                take,
  output logic                out_valid,
  input  wire logic           out_stall,
  output phv_pkg::rslt_t      rslt
);

  logic [15:0] idx_r, idx_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] ack_r, ack_nxt;
  logic [15:0] csum_r, csum_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] tw_r, tw_nxt;
  logic        out_valid_r, out_valid_nxt;
  phv_pkg::rslt_t rslt_r, rslt_nxt;

  logic [15:0] cnt;
  logic [15:0] sum_upd;
  logic [15:0] fin_sum;
  logic [7:0]  b;
  logic        in_sum;

  // advance when the result register is free or being emptied
  assign take = item_valid && (!out_valid_r || !out_stall);

  always_comb begin
    b        = item.byte_in;
    seq_nxt  = seq_r;
    ack_nxt  = ack_r;
    csum_nxt = csum_r;
    len_nxt  = len_r;
    tw_nxt   = tw_r;
    hi_nxt   = hi_r;
    sum_upd  = sum_r;
    fin_sum  = '0;
    rslt_nxt = '0;

    if (idx_r < phv_pkg::SEQ_END) begin
      seq_nxt = {seq_r[23:0], b};
    end else if (idx_r < phv_pkg::ACK_END) begin
      ack_nxt = {ack_r[23:0], b};
    end else if (idx_r < phv_pkg::CSUM_END) begin
      csum_nxt = {csum_r[7:0], b};
    end else if (idx_r < phv_pkg::LEN_END) begin
      len_nxt = {len_r[7:0], b};
    end else if (idx_r < phv_pkg::HDR_BYTES) begin
      tw_nxt = {tw_r[7:0], b};
    end

    // checksum bytes count as zero
    in_sum = (idx_r < phv_pkg::LEN_END) || (idx_r < len_r);
    if (in_sum && idx_r != phv_pkg::CSUM_HI && idx_r != phv_pkg::CSUM_LO) begin
      if (!idx_r[0]) begin
        hi_nxt = b;
      end else begin
        sum_upd = phv_pkg::add_carry(sum_r, {hi_r, b});
      end
    end

    cnt = (idx_r != phv_pkg::IDX_MAX) ? idx_r + 16'd1 : idx_r;

    rslt_nxt.payload_byte  = b;
    rslt_nxt.payload_valid = (idx_r >= phv_pkg::HDR_BYTES) && (idx_r < len_r);

    idx_nxt = cnt;
    sum_nxt = sum_upd;

    if (item.last_byte) begin
      rslt_nxt.packet_done = 1'b1;
      // odd length: trailing byte is the high half of a zero-padded word
      fin_sum = len_nxt[0] ? phv_pkg::add_carry(sum_upd, {hi_nxt, 8'd0}) : sum_upd;
      if (cnt < phv_pkg::HDR_BYTES) begin
        rslt_nxt.status = phv_pkg::ST_UNDER_HDR;
      end else begin
        if (len_nxt < phv_pkg::HDR_BYTES) begin
          rslt_nxt.status = phv_pkg::ST_LEN_SHORT;
        end else if (cnt < len_nxt) begin
          rslt_nxt.status = phv_pkg::ST_TRUNC;
        end else if (~fin_sum != csum_nxt) begin
          rslt_nxt.status = phv_pkg::ST_CSUM_BAD;
        end else begin
          rslt_nxt.status = phv_pkg::ST_OK;
        end
        rslt_nxt.sequence_number = seq_nxt;
        rslt_nxt.ack_number      = ack_nxt;
        rslt_nxt.packet_type     = tw_nxt[15:8];
        rslt_nxt.window_size     = tw_nxt[7:0];
      end
      if (rslt_nxt.status == phv_pkg::ST_OK) begin
        rslt_nxt.payload_length = len_nxt - phv_pkg::HDR_BYTES;
      end
      idx_nxt = '0;
      sum_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      sum_r       <= '0;
      hi_r        <= '0;
      seq_r       <= '0;
      ack_r       <= '0;
      csum_r      <= '0;
      len_r       <= '0;
      tw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        idx_r  <= idx_nxt;
        sum_r  <= sum_nxt;
        hi_r   <= hi_nxt;
        seq_r  <= seq_nxt;
        ack_r  <= ack_nxt;
        csum_r <= csum_nxt;
        len_r  <= len_nxt;
        tw_r   <= tw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rslt_r <= rslt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign rslt      = rslt_r;

  `PHV_ASSERT(a_clear_after_last, clk, rst_n, (take && item.last_byte) |=> (idx_r == 16'd0 && sum_r == 16'd0), "count or sum not cleared after last item")
  `PHV_ASSERT(a_mid_fields_zero, clk, rst_n, (out_valid_r && !rslt_r.packet_done) |-> (rslt_r.status == phv_pkg::ST_OK && rslt_r.payload_length == 16'd0 && rslt_r.sequence_number == 32'd0), "status fields set before last item")
  `PHV_ASSERT(a_ok_length, clk, rst_n, (out_valid_r && rslt_r.packet_done && rslt_r.status == phv_pkg::ST_OK) |-> (rslt_r.payload_length == len_r - phv_pkg::HDR_BYTES), "payload length mismatch")
  `PHV_ASSERT(a_bad_no_length, clk, rst_n, (out_valid_r && rslt_r.status != phv_pkg::ST_OK) |-> (rslt_r.payload_length == 16'd0), "length reported on failed packet")

endmodule

`default_nettype wire

// ===== hw/rtl/packet_header_parse_and_verify_top.sv =====
// ----------------------------------------------------------------------------
// packet_header_parse_and_verify_top
// Streaming datagram header decode and internet-checksum verification.
// ----------------------------------------------------------------------------
// Bytes of one datagram enter in wire order, one item per cycle while in_stall
// is low, with in_last_byte marking the final byte. Every input item produces
// exactly one result item through the input register, then the result register,
// and a new item can be accepted every clock while out_stall is low, so the
// sustained rate is one byte per cycle; the path that sets this is the 16-bit
// end-around-carry add plus the final compare in the core. Bytes from index 14
// below the length field come out with out_payload_valid set as they pass; the
// consumer must drop them unless the result carrying out_packet_done reports
// status ok. On that final result the decoded sequence, ack, type and window
// fields, and for status ok the payload length, are shown; when fewer than 14
// bytes arrived they read zero. Status order of precedence: under header, length
// field below 14, truncated, checksum bad. The byte count saturates at 65535.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packet_header_parse_and_verify_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_last_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_payload_byte,
  output logic             out_payload_valid,
  output logic             out_packet_done,
  output logic [2:0]       out_status,
  output logic [31:0]      out_sequence_number,
  output logic [31:0]      out_ack_number,
  output logic [7:0]       out_packet_type,
  output logic [7:0]       out_window_size,
  output logic [15:0]      out_payload_length
);

  phv_pkg::item_t in_item;
  phv_pkg::item_t item;
  phv_pkg::rslt_t rslt;
  logic           item_valid;
  logic           take;

  assign in_item.byte_in   = in_byte_in;
  assign in_item.last_byte = in_last_byte;

  // input register; stalls upstream only when its held item cannot advance
  phv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // decode, checksum and status; owns the result register
  phv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rslt       (rslt)
  );

  assign out_payload_byte    = rslt.payload_byte;
  assign out_payload_valid   = rslt.payload_valid;
  assign out_packet_done     = rslt.packet_done;
  assign out_status          = rslt.status;
  assign out_sequence_number = rslt.sequence_number;
  assign out_ack_number      = rslt.ack_number;
  assign out_packet_type     = rslt.packet_type;
  assign out_window_size     = rslt.window_size;
  assign out_payload_length  = rslt.payload_length;

endmodule

`default_nettype wire
